### design/dbps_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dbps_pkg: shared types and constants of the drum bus stage
// Sequencer state and operation codes, rounding selects for the digit-serial
// multiplier, fixed filter coefficients and configuration register indexes.
// ----------------------------------------------------------------------------
package dbps_pkg;

    // Multiplier digit size; the coefficient operands are 16 bits wide.
    localparam int DIGIT_W  = 4;
    localparam int ND_COEF  = 16 / DIGIT_W;

    // Fixed coefficients, unsigned Q0.16.
    localparam logic [15:0] K_TRACK = 16'd7209;
    localparam logic [15:0] K_PUNCH = 16'd62259;
    localparam logic [15:0] K_PRE   = 16'd40632;
    localparam logic [15:0] K_RIGHT = 16'd65339;

    // Configuration register indexes.
    localparam logic [1:0] CFG_LOWPASS_COEFF = 2'd0;
    localparam logic [1:0] CFG_DRIVE_GAIN    = 2'd1;
    localparam logic [1:0] CFG_DRIVE_TRIM    = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [15:0] RST_LOWPASS_COEFF = 16'd15401;
    localparam logic [14:0] RST_DRIVE_GAIN    = 15'd11436;
    localparam logic [15:0] RST_DRIVE_TRIM    = 16'd39222;

    // Rounding shift applied to a finished product.
    typedef enum logic [1:0] {
        SH_NONE,
        SH_12,
        SH_16,
        SH_FRAC
    } t_shift;

    typedef struct packed {
        logic   start;
        t_shift shift;
    } t_mul_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT,
        S_ROM_LO,
        S_ROM_HI,
        S_ROM_CAP,
        S_OUT
    } t_state;

    typedef enum logic [3:0] {
        OP_TRACK,
        OP_PUNCH,
        OP_PRE,
        OP_GAIN,
        OP_POS,
        OP_INTERP,
        OP_TRIM,
        OP_LEFT,
        OP_TARGET,
        OP_RIGHT
    } t_op;

endpackage
`default_nettype wire

### design/dbps_serial_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dbps_serial_mul: digit-serial signed by unsigned multiplier
// Multiplies a signed operand by an unsigned one, four multiplier bits per
// cycle, most significant digit first, then rounds to nearest but for SH_NONE.
// ----------------------------------------------------------------------------
module dbps_serial_mul
    import dbps_pkg::*;
#(
    parameter int  SAMPLE_WIDTH     = 24,
    parameter int  TANH_TABLE_DEPTH = 256,
    localparam int DB    = $clog2(TANH_TABLE_DEPTH + 1),
    localparam int AW    = SAMPLE_WIDTH + 4,
    localparam int MB    = (SAMPLE_WIDTH - 2 > 16) ? SAMPLE_WIDTH - 2 : 16,
    localparam int ND_F  = (SAMPLE_WIDTH - 2 + DIGIT_W - 1) / DIGIT_W,
    localparam int ND_D  = (DB + DIGIT_W - 1) / DIGIT_W,
    localparam int NDMAX = (MB + DIGIT_W - 1) / DIGIT_W,
    localparam int BL    = NDMAX * DIGIT_W,
    localparam int PW    = AW + BL,
    localparam int CW    = $clog2(NDMAX + 1)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_mul_req             i_req,
    input  wire logic signed [AW-1:0] i_a,
    input  wire logic [MB-1:0]        i_b,
    output logic signed [PW-1:0]      o_res,
    output logic                      o_done
);

    logic                 r_busy;
    logic                 r_fin;
    logic                 r_done;
    logic [CW-1:0]        r_cnt;
    logic signed [AW-1:0] r_a;
    logic [BL-1:0]        r_b;
    logic signed [PW-1:0] r_acc;
    logic signed [PW-1:0] r_res;
    t_shift               r_shift;

    logic [DIGIT_W-1:0]           w_digit;
    logic signed [AW+DIGIT_W:0]   w_pp;
    logic signed [PW-1:0]         w_acc_next;
    logic [BL-1:0]                w_b_load;
    logic [CW-1:0]                w_n_load;
    logic signed [PW-1:0]         w_half;
    logic signed [PW-1:0]         w_sum;
    logic signed [PW-1:0]         w_rnd;

    assign w_digit    = r_b[BL-1 -: DIGIT_W];
    assign w_pp       = r_a * $signed({1'b0, w_digit});
    assign w_acc_next = (r_acc <<< DIGIT_W) + PW'(w_pp);

    // The multiplier operand is left aligned so that its top used digit
    // comes out first.
    always_comb begin
        case (i_req.shift) inside
            SH_NONE: begin
                w_n_load = CW'(ND_D);
                w_b_load = BL'(i_b) << (BL - ND_D * DIGIT_W);
            end
            SH_FRAC: begin
                w_n_load = CW'(ND_F);
                w_b_load = BL'(i_b) << (BL - ND_F * DIGIT_W);
            end
            SH_12, SH_16: begin
                w_n_load = CW'(ND_COEF);
                w_b_load = BL'(i_b) << (BL - ND_COEF * DIGIT_W);
            end
            default: begin
                w_n_load = CW'(ND_COEF);
                w_b_load = BL'(i_b) << (BL - ND_COEF * DIGIT_W);
            end
        endcase
    end

    // Round to nearest, ties toward plus infinity.
    always_comb begin
        w_half = '0;
        case (r_shift)
            SH_12:   w_half[11] = 1'b1;
            SH_16:   w_half[15] = 1'b1;
            SH_FRAC: w_half[SAMPLE_WIDTH-3] = 1'b1;
            default: w_half = '0;
        endcase
        w_sum = r_acc + w_half;
        case (r_shift)
            SH_12:   w_rnd = w_sum >>> 12;
            SH_16:   w_rnd = w_sum >>> 16;
            SH_FRAC: w_rnd = w_sum >>> (SAMPLE_WIDTH - 2);
            default: w_rnd = r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_fin;
            r_fin  <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= w_n_load;
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a     <= i_a;
            r_b     <= w_b_load;
            r_acc   <= '0;
            r_shift <= i_req.shift;
        end else if (r_busy) begin
            r_acc <= w_acc_next;
            r_b   <= r_b << DIGIT_W;
        end
        if (r_fin) begin
            r_res <= w_rnd;
        end
    end

    assign o_res  = r_res;
    assign o_done = r_done;

`ifndef ASSERT_OFF
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> (!r_busy && !r_fin))
        else $error("multiplier started while a product is in progress");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("multiplier done held for more than one cycle");
`endif

endmodule
`default_nettype wire

### design/dbps_tanh_rom.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dbps_tanh_rom: tanh lookup table with registered read
// Holds tanh(4*i/depth) for i = 0..depth in FRAC fraction bits, computed at
// elaboration from an exp(-2x) series squared four times.
// ----------------------------------------------------------------------------
module dbps_tanh_rom #(
    parameter int  SAMPLE_WIDTH     = 24,
    parameter int  TANH_TABLE_DEPTH = 256,
    localparam int DB = $clog2(TANH_TABLE_DEPTH + 1),
    localparam int EW = SAMPLE_WIDTH - 3
) (
    input  wire logic          i_clk,
    input  wire logic [DB-1:0] i_addr,
    output logic [EW-1:0]      o_data
);

    localparam int                FRAC = SAMPLE_WIDTH - 4;
    localparam longint unsigned   Q31  = 64'd1 << 31;

    // Restoring long division, used only while the table is built.
    function automatic longint unsigned udiv(input longint unsigned num,
                                             input longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], num[b]};
            if (r >= den) begin
                r    = r - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic longint unsigned tanh_entry(input longint unsigned idx);
        longint unsigned a;
        longint unsigned term;
        longint unsigned e;
        longint unsigned den;
        longint          sum;
        a    = udiv((idx << 31) + 64'(TANH_TABLE_DEPTH), 64'(TANH_TABLE_DEPTH) << 1);
        term = Q31;
        sum  = Q31;
        for (longint unsigned k = 1; k <= 14; k++) begin
            term = udiv((term * a) >> 31, k);
            if (k[0]) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > Q31) begin
            sum = Q31;
        end
        e = sum;
        for (int s = 0; s < 4; s++) begin
            e = (e * e + (64'd1 << 30)) >> 31;
        end
        den = Q31 + e;
        return udiv(((Q31 - e) << FRAC) + (den >> 1), den);
    endfunction

    logic [EW-1:0] w_rom [0:(1 << DB) - 1];
    logic [EW-1:0] r_data;

    for (genvar g = 0; g < (1 << DB); g++) begin : g_rom
        if (g <= TANH_TABLE_DEPTH) begin : g_entry
            localparam logic [EW-1:0] ENTRY = EW'(tanh_entry(64'(g)));
            assign w_rom[g] = ENTRY;
        end else begin : g_pad
            assign w_rom[g] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= w_rom[i_addr];
    end

    assign o_data = r_data;

endmodule
`default_nettype wire

### design/drum_bus_punch_saturate_lowpass_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// drum_bus_punch_saturate_lowpass_top: drum synth master bus stage
// Punch tracker, drive and tanh saturation, trim and stereo output lowpass.
// ----------------------------------------------------------------------------
// One mono item enters on the s_axis channel (tdata: mono_sum, Q3.20 signed;
// tuser: voice_started) and one stereo item leaves on m_axis (tdata:
// left_sample low, right_sample above it). The user must write the three
// registers on the cfg port (lowpass coefficient, drive gain, trim) only
// while no item is in flight; the block does not enforce this. Every
// arithmetic step is one product on a shared multiplier that consumes four
// multiplier bits per cycle, so an item walks through ten products in turn
// plus two reads of the tanh table. A coefficient product runs over ND_COEF
// multiplier digits, the table position product over ND_D and the
// interpolation over ND_F, the digit counts of the table index and of the
// fraction. s_axis tready is high only while no item is being worked on.
// The finished item waits in the output register; a stall on m_axis holds
// it there and the next item is still accepted and computed, delivery
// waiting only until the register is free. Reset clears the tracker and
// both lowpass states, restores the register defaults and empties the
// output register; the tanh table is fixed logic and needs no fill.
// ----------------------------------------------------------------------------
module drum_bus_punch_saturate_lowpass_top
    import dbps_pkg::*;
#(
    parameter int  SAMPLE_WIDTH     = 24,
    parameter int  TANH_TABLE_DEPTH = 256,
    localparam int SDW = ((SAMPLE_WIDTH + 7) / 8) * 8,
    localparam int ODW = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    // Input stream. tdata: mono_sum [SAMPLE_WIDTH-1:0], zero padding above.
    input  wire logic                                      i_s_axis_tvalid,
    output logic                                           o_s_axis_tready,
    input  wire logic [SDW-1:0]                            i_s_axis_tdata,
    // tuser: voice_started [0].
    input  wire logic                                      i_s_axis_tuser,
    // Output stream. tdata: left_sample [SAMPLE_WIDTH-1:0], then right_sample,
    // zero padding above.
    output logic                                           o_m_axis_tvalid,
    input  wire logic                                      i_m_axis_tready,
    output logic [ODW-1:0]                                 o_m_axis_tdata,
    // Configuration write port.
    input  wire logic                                      i_cfg_we,
    input  wire logic [1:0]                                i_cfg_index,
    input  wire logic [15:0]                               i_cfg_data
);

    localparam int W     = SAMPLE_WIDTH;
    localparam int FRAC  = W - 4;
    localparam int DB    = $clog2(TANH_TABLE_DEPTH + 1);
    localparam int AW    = W + 4;
    localparam int MB    = (W - 2 > 16) ? W - 2 : 16;
    localparam int NDMAX = (MB + DIGIT_W - 1) / DIGIT_W;
    localparam int PW    = AW + NDMAX * DIGIT_W;
    localparam int TW    = W + 1;   // punch tracker
    localparam int YW    = W - 1;   // saturator output and trimmed sample
    localparam int MGW   = W - 1;   // clamped saturator input magnitude
    localparam int EW    = W - 3;   // tanh table entry

    // Clamp point of the saturator input, 4.0.
    localparam logic [AW-1:0] MAG_LIMIT = AW'(64'd1 << (W - 2));
    // Silence: |mono| * 10^7 < 2^FRAC, as an integer bound on |mono|.
    localparam logic [W-1:0]  CLR_LIM =
        W'(((64'd1 << FRAC) + 64'd9999999) / 64'd10000000);

    // Configuration registers.
    logic [15:0] r_coeff;
    logic [14:0] r_gain;
    logic [15:0] r_trim;

    // Sequencer.
    t_state r_state, n_state;
    t_op    r_op, n_op;

    // Filter state and working registers.
    logic signed [TW-1:0] r_track;
    logic signed [W-1:0]  r_left;
    logic signed [W-1:0]  r_right;
    logic signed [W-1:0]  r_mono;
    logic signed [AW-1:0] r_work;
    logic signed [YW-1:0] r_m;
    logic                 r_neg;
    logic [MGW-1:0]       r_mag;
    logic [DB-1:0]        r_idx;
    logic [W-3:0]         r_frac;
    logic [EW-1:0]        r_lo;
    logic [EW-1:0]        r_hi;

    // Output register.
    logic                 r_out_valid;
    logic [2*W-1:0]       r_out_data;

    // Multiplier and table.
    t_mul_req             w_mul_req;
    logic                 w_mul_start;
    t_shift               w_mul_shift;
    logic signed [AW-1:0] w_mul_a;
    logic [MB-1:0]        w_mul_b;
    logic signed [PW-1:0] w_res;
    logic                 w_mul_done;
    logic [DB-1:0]        w_rom_addr;
    logic [EW-1:0]        w_rom_data;

    logic                 w_in_acc;
    logic                 w_out_free;
    logic signed [W-1:0]  w_mono_in;
    logic [W-1:0]         w_in_mag;
    logic                 w_clear;
    logic signed [AW-1:0] w_res_a;
    logic signed [AW-1:0] w_track_sum;
    logic signed [AW-1:0] w_punch;
    logic signed [AW-1:0] w_absx;
    logic [AW-1:0]        w_clamp;
    logic signed [YW-1:0] w_y;
    logic signed [YW-1:0] w_ys;
    logic signed [AW-1:0] w_left_sum;
    logic signed [AW-1:0] w_right_sum;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_out_valid || i_m_axis_tready;

    // Silence detection on the incoming item.
    assign w_mono_in = i_s_axis_tdata[W-1:0];
    assign w_in_mag  = w_mono_in[W-1] ? W'(-w_mono_in) : W'(w_mono_in);
    assign w_clear   = !i_s_axis_tuser && (w_in_mag < CLR_LIM);

    // Configuration writes; an index past the last register is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coeff <= RST_LOWPASS_COEFF;
            r_gain  <= RST_DRIVE_GAIN;
            r_trim  <= RST_DRIVE_TRIM;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LOWPASS_COEFF: r_coeff <= i_cfg_data;
                CFG_DRIVE_GAIN:    r_gain  <= i_cfg_data[14:0];
                CFG_DRIVE_TRIM:    r_trim  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Operands of each product, selected by the current step.
    always_comb begin
        w_mul_a = r_work;
        w_mul_b = MB'(K_TRACK);
        w_mul_shift = SH_16;
        case (r_op) inside
            OP_TRACK, OP_PUNCH: begin
                w_mul_a = AW'(r_mono) - AW'(r_track);
                w_mul_b = (r_op == OP_TRACK) ? MB'(K_TRACK) : MB'(K_PUNCH);
            end
            OP_PRE: begin
                w_mul_b = MB'(K_PRE);
            end
            OP_GAIN: begin
                w_mul_b = MB'(r_gain);
                w_mul_shift = SH_12;
            end
            OP_POS: begin
                w_mul_a = AW'(r_mag);
                w_mul_b = MB'(TANH_TABLE_DEPTH);
                w_mul_shift = SH_NONE;
            end
            OP_INTERP: begin
                w_mul_a = AW'(r_hi) - AW'(r_lo);
                w_mul_b = MB'(r_frac);
                w_mul_shift = SH_FRAC;
            end
            OP_TRIM: begin
                w_mul_b = MB'(r_trim);
            end
            OP_LEFT: begin
                w_mul_a = AW'(r_m) - AW'(r_left);
                w_mul_b = MB'(r_coeff);
            end
            OP_TARGET: begin
                w_mul_a = AW'(r_m);
                w_mul_b = MB'(K_RIGHT);
            end
            OP_RIGHT: begin
                w_mul_a = r_work - AW'(r_right);
                w_mul_b = MB'(r_coeff);
            end
            default: begin
                w_mul_a = r_work;
            end
        endcase
    end

    assign w_mul_req = '{start: w_mul_start, shift: w_mul_shift};

    // Next state and multiplier start.
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        w_mul_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_state = S_ISSUE;
                    n_op    = OP_TRACK;
                end
            end
            S_ISSUE: begin
                w_mul_start = 1'b1;
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (w_mul_done) begin
                    n_state = S_ISSUE;
                    unique case (r_op)
                        OP_TRACK:  n_op = OP_PUNCH;
                        OP_PUNCH:  n_op = OP_PRE;
                        OP_PRE:    n_op = OP_GAIN;
                        OP_GAIN:   n_op = OP_POS;
                        OP_POS:    n_state = S_ROM_LO;
                        OP_INTERP: n_op = OP_TRIM;
                        OP_TRIM:   n_op = OP_LEFT;
                        OP_LEFT:   n_op = OP_TARGET;
                        OP_TARGET: n_op = OP_RIGHT;
                        OP_RIGHT:  n_state = S_OUT;
                        default:   n_state = S_OUT;
                    endcase
                end
            end
            S_ROM_LO:  n_state = S_ROM_HI;
            S_ROM_HI:  n_state = S_ROM_CAP;
            S_ROM_CAP: begin
                n_op    = OP_INTERP;
                n_state = S_ISSUE;
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_TRACK;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    // Results of the products.
    assign w_res_a     = w_res[AW-1:0];
    assign w_track_sum = AW'(r_track) + w_res_a;
    assign w_punch     = AW'(r_mono) + w_res_a;
    assign w_absx      = w_res_a[AW-1] ? -w_res_a : w_res_a;
    assign w_clamp     = (w_absx > $signed(MAG_LIMIT)) ? MAG_LIMIT : w_absx;
    assign w_y         = YW'(r_lo) + w_res[YW-1:0];
    assign w_ys        = r_neg ? -w_y : w_y;
    assign w_left_sum  = AW'(r_left) + w_res_a;
    assign w_right_sum = AW'(r_right) + w_res_a;

    // The second table read is the next entry, held at the last one so that
    // a clamped input reads the end value with a zero fraction.
    assign w_rom_addr = (r_state == S_ROM_HI && r_idx != DB'(TANH_TABLE_DEPTH))
                      ? r_idx + DB'(1) : r_idx;

    // Filter state, cleared at reset and on a silent item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track <= '0;
            r_left  <= '0;
            r_right <= '0;
        end else if (w_in_acc && w_clear) begin
            r_track <= '0;
            r_left  <= '0;
            r_right <= '0;
        end else if (r_state == S_WAIT && w_mul_done) begin
            case (r_op)
                OP_TRACK: r_track <= w_track_sum[TW-1:0];
                OP_LEFT:  r_left  <= w_left_sum[W-1:0];
                OP_RIGHT: r_right <= w_right_sum[W-1:0];
                default: ;
            endcase
        end
    end

    // Working registers of the item in flight.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_mono <= w_mono_in;
        end
        if (r_state == S_ROM_HI) begin
            r_lo <= w_rom_data;
        end
        if (r_state == S_ROM_CAP) begin
            r_hi <= w_rom_data;
        end
        if (r_state == S_WAIT && w_mul_done) begin
            case (r_op)
                OP_PUNCH:  r_work <= w_punch;
                OP_PRE:    r_work <= w_res_a;
                OP_GAIN: begin
                    r_neg <= w_res_a[AW-1];
                    r_mag <= w_clamp[MGW-1:0];
                end
                OP_POS: begin
                    r_idx  <= w_res[W-2 +: DB];
                    r_frac <= w_res[W-3:0];
                end
                OP_INTERP: r_work <= AW'(w_ys);
                OP_TRIM:   r_m    <= w_res_a[YW-1:0];
                OP_TARGET: r_work <= w_res_a;
                default: ;
            endcase
        end
    end

    // Output register: the result waits here until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && w_out_free) begin
            r_out_data <= {r_right, r_left};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = ODW'(r_out_data);

    dbps_serial_mul #(
        .SAMPLE_WIDTH     (SAMPLE_WIDTH),
        .TANH_TABLE_DEPTH (TANH_TABLE_DEPTH)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mul_req),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_res   (w_res),
        .o_done  (w_mul_done)
    );

    dbps_tanh_rom #(
        .SAMPLE_WIDTH     (SAMPLE_WIDTH),
        .TANH_TABLE_DEPTH (TANH_TABLE_DEPTH)
    ) u_rom (
        .i_clk  (i_clk),
        .i_addr (w_rom_addr),
        .o_data (w_rom_data)
    );

`ifndef ASSERT_OFF
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !o_s_axis_tready)
        else $error("input still ready right after an item was accepted");
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_done |-> (r_state == S_WAIT))
        else $error("product finished outside the wait state");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_out_valid && !i_m_axis_tready)
        |=> (r_state == S_OUT && $stable(r_out_data)))
        else $error("pending output item overwritten during a stall");
`endif

endmodule
`default_nettype wire
